>>> design/vrp_pkg.sv
// Shared types and constants for the vertex rotate and project block.
package vrp_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_COS_ANGLE     = 3'd0;
   localparam logic [2:0] CSR_SIN_ANGLE     = 3'd1;
   localparam logic [2:0] CSR_OFFSET_X      = 3'd2;
   localparam logic [2:0] CSR_OFFSET_Y      = 3'd3;
   localparam logic [2:0] CSR_OFFSET_Z      = 3'd4;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd5;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd6;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int ANGLE_WIDTH     = 16;
   localparam int OFFSET_WIDTH    = 16;
   localparam int SCREEN_WIDTH    = 13;
   localparam int SCALE_WIDTH     = SCREEN_WIDTH - 1;

   // Angle values carry 14 fraction bits.
   localparam int ANGLE_FRAC = 14;

   // Reset values of the registers.
   localparam logic signed [ANGLE_WIDTH-1:0]  COS_RESET    = 16'sd16384;
   localparam logic signed [ANGLE_WIDTH-1:0]  SIN_RESET    = 16'sd0;
   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_RESET = 16'sd0;
   localparam logic [SCREEN_WIDTH-1:0]        WIDTH_RESET  = 13'd640;
   localparam logic [SCREEN_WIDTH-1:0]        HEIGHT_RESET = 13'd480;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0]  cos_angle;
      logic signed [ANGLE_WIDTH-1:0]  sin_angle;
      logic signed [OFFSET_WIDTH-1:0] offset_x;
      logic signed [OFFSET_WIDTH-1:0] offset_y;
      logic signed [OFFSET_WIDTH-1:0] offset_z;
      logic [SCREEN_WIDTH-1:0]        screen_width;
      logic [SCREEN_WIDTH-1:0]        screen_height;
   } vrp_cfg_type;

   // Side flags that travel with an item through the divider chain.
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic behind;
   } vrp_flags_type;

endpackage

>>> design/vrp_front.sv
// Front pipeline: rotation, translation, scaling and operand preparation for the divider.
module vrp_front #(
   parameter int CW = 16,
   parameter int FB = 12,
   parameter int RW = 20,
   parameter int DW = 21,
   parameter int NM = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vrp_pkg::vrp_cfg_type     cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [CW-1:0]            in_x,
   input  logic [CW-1:0]            in_y,
   input  logic [CW-1:0]            in_z,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [DW-2:0]            out_divisor,
   output logic [NM-1:0]            out_mag_x,
   output logic [NM-1:0]            out_mag_y,
   output vrp_pkg::vrp_flags_type   out_flags
);
   import vrp_pkg::*;

   localparam int PW   = CW + ANGLE_WIDTH;
   localparam int SUMW = PW + 1;
   localparam int NW   = NM + 1;
   localparam int DM   = DW - 1;
   localparam logic signed [DW-1:0] D_ONE = DW'(1) << FB;

   // Stage valids and ready chain.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   // Stage 1 registers: rotation products.
   logic signed [PW-1:0] p_xc_ff, p_zs_ff, p_zc_ff, p_xs_ff;
   logic signed [PW-1:0] p_xc_in, p_zs_in, p_zc_in, p_xs_in;
   logic signed [CW-1:0] y1_ff;

   // Stage 2 registers: translated point, divisor and scale.
   logic signed [RW-1:0] rx_ff, ry_ff, rx_in, ry_in, rz;
   logic signed [DW-1:0] d2_ff, d2_in;
   logic [SCALE_WIDTH-1:0] scale_ff, scale_in;
   logic [SCREEN_WIDTH-1:0] min_side;
   logic signed [SUMW-1:0] sum_x, sum_z;

   // Stage 3 registers: numerators and behind flag.
   logic signed [NW-1:0] num_x_ff, num_y_ff, num_x_in, num_y_in;
   logic signed [DW-1:0] d3_ff;
   logic behind_ff, behind_in;

   // Stage 4 registers: magnitudes for the divider.
   logic [DM-1:0] div_ff;
   logic [NM-1:0] mag_x_ff, mag_y_ff;
   vrp_flags_type flags_ff;

   logic signed [CW-1:0] x_s, y_s, z_s;
   logic signed [ANGLE_WIDTH-1:0] cos_s, sin_s;

   assign r4 = !v4_ff || out_ready;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   assign x_s   = in_x;
   assign y_s   = in_y;
   assign z_s   = in_z;
   assign cos_s = cfg.cos_angle;
   assign sin_s = cfg.sin_angle;

   // Four rotation products.
   always_comb begin
      p_xc_in = x_s * cos_s;
      p_zs_in = z_s * sin_s;
      p_zc_in = z_s * cos_s;
      p_xs_in = x_s * sin_s;
   end

   // Sum the products exactly, floor back to coordinate scale and translate.
   always_comb begin
      sum_x    = SUMW'(p_xc_ff) + SUMW'(p_zs_ff);
      sum_z    = SUMW'(p_zc_ff) - SUMW'(p_xs_ff);
      rx_in    = RW'(sum_x >>> ANGLE_FRAC) + RW'(cfg.offset_x);
      rz       = RW'(sum_z >>> ANGLE_FRAC) + RW'(cfg.offset_z);
      ry_in    = RW'(y1_ff) + RW'(cfg.offset_y);
      d2_in    = DW'(rz) + D_ONE;
      min_side = (cfg.screen_width < cfg.screen_height) ? cfg.screen_width
                                                         : cfg.screen_height;
      scale_in = min_side[SCREEN_WIDTH-1:1];
   end

   // Scale the numerators and classify the divisor.
   always_comb begin
      num_x_in  = rx_ff * $signed({1'b0, scale_ff});
      num_y_in  = ry_ff * $signed({1'b0, scale_ff});
      behind_in = d2_ff[DW-1] || (d2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   // Datapath registers advance with their stage.
   always_ff @(posedge clock) begin
      if (r1) begin
         p_xc_ff <= p_xc_in;
         p_zs_ff <= p_zs_in;
         p_zc_ff <= p_zc_in;
         p_xs_ff <= p_xs_in;
         y1_ff   <= y_s;
      end
      if (r2) begin
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         d2_ff    <= d2_in;
         scale_ff <= scale_in;
      end
      if (r3) begin
         num_x_ff  <= num_x_in;
         num_y_ff  <= num_y_in;
         d3_ff     <= d2_ff;
         behind_ff <= behind_in;
      end
      if (r4) begin
         div_ff          <= d3_ff[DM-1:0];
         mag_x_ff        <= NM'(num_x_ff[NW-1] ? -num_x_ff : num_x_ff);
         mag_y_ff        <= NM'(num_y_ff[NW-1] ? -num_y_ff : num_y_ff);
         flags_ff.neg_x  <= num_x_ff[NW-1];
         flags_ff.neg_y  <= num_y_ff[NW-1];
         flags_ff.behind <= behind_ff;
      end
   end

   assign out_valid   = v4_ff;
   assign out_divisor = div_ff;
   assign out_mag_x   = mag_x_ff;
   assign out_mag_y   = mag_y_ff;
   assign out_flags   = flags_ff;

endmodule

>>> design/vrp_div_cell.sv
// One cell of the divider chain: one restoring step for the x and y lanes.
module vrp_div_cell #(
   parameter int DM = 20,
   parameter int NM = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [DM-1:0]            in_divisor,
   input  logic [DM-1:0]            in_rem_x,
   input  logic [DM-1:0]            in_rem_y,
   input  logic [NM-1:0]            in_numq_x,
   input  logic [NM-1:0]            in_numq_y,
   input  vrp_pkg::vrp_flags_type   in_flags,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [DM-1:0]            out_divisor,
   output logic [DM-1:0]            out_rem_x,
   output logic [DM-1:0]            out_rem_y,
   output logic [NM-1:0]            out_numq_x,
   output logic [NM-1:0]            out_numq_y,
   output vrp_pkg::vrp_flags_type   out_flags
);
   import vrp_pkg::*;

   logic valid_ff;
   logic [DM-1:0] div_ff, rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [NM-1:0] numq_x_ff, numq_y_ff, numq_x_in, numq_y_in;
   vrp_flags_type flags_ff;
   logic [DM:0]   t_x, t_y;
   logic [DM+1:0] diff_x, diff_y;
   logic          take_x, take_y;

   assign in_ready = !valid_ff || out_ready;

   // Bring down the next numerator bit and subtract the divisor if it fits.
   always_comb begin
      t_x       = {in_rem_x, in_numq_x[NM-1]};
      t_y       = {in_rem_y, in_numq_y[NM-1]};
      diff_x    = {1'b0, t_x} - {2'b00, in_divisor};
      diff_y    = {1'b0, t_y} - {2'b00, in_divisor};
      take_x    = !diff_x[DM+1];
      take_y    = !diff_y[DM+1];
      rem_x_in  = take_x ? diff_x[DM-1:0] : t_x[DM-1:0];
      rem_y_in  = take_y ? diff_y[DM-1:0] : t_y[DM-1:0];
      numq_x_in = {in_numq_x[NM-2:0], take_x};
      numq_y_in = {in_numq_y[NM-2:0], take_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         div_ff    <= in_divisor;
         rem_x_ff  <= rem_x_in;
         rem_y_ff  <= rem_y_in;
         numq_x_ff <= numq_x_in;
         numq_y_ff <= numq_y_in;
         flags_ff  <= in_flags;
      end
   end

   assign out_valid   = valid_ff;
   assign out_divisor = div_ff;
   assign out_rem_x   = rem_x_ff;
   assign out_rem_y   = rem_y_ff;
   assign out_numq_x  = numq_x_ff;
   assign out_numq_y  = numq_y_ff;
   assign out_flags   = flags_ff;

`ifndef SYNTHESIS
   // A partial remainder always stays below a valid divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !flags_ff.behind |-> (rem_x_ff < div_ff) && (rem_y_ff < div_ff))
      else $error("divider cell remainder not below divisor");
`endif

endmodule

>>> design/vertex_rotate_project.sv
// An accepted item passes through four front stages, one divider cell per quotient bit,
// and the output register.
// Throughput: one item per cycle while the output is not stalled; each divider cell holds one item and passes it on.
// Stalls fill bubbles first, so the input is held only when every stage is occupied.
// Reset clears all valid bits and loads the configuration registers with their power-on values.
// Top level of the vertex rotate and project pipeline.
module vertex_rotate_project #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [COORD_WIDTH-1:0]                req_vertex_x,
   input  logic [COORD_WIDTH-1:0]                req_vertex_y,
   input  logic [COORD_WIDTH-1:0]                req_vertex_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [COORD_WIDTH-1:0]                rsp_screen_x,
   output logic [COORD_WIDTH-1:0]                rsp_screen_y,
   output logic                                  rsp_behind_viewer,
   input  logic                                  csr_write,
   input  logic [vrp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [vrp_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import vrp_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int RSW = CW + 3;
   localparam int RW  = ((RSW > OFFSET_WIDTH) ? RSW : OFFSET_WIDTH) + 1;
   localparam int DW  = ((RW > FRAC_BITS + 2) ? RW : FRAC_BITS + 2) + 1;
   localparam int DM  = DW - 1;
   localparam int NM  = RW + 12;
   localparam logic [NM-1:0] MAG_MAX = NM'((64'(1) << (CW - 1)) - 1);
   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   // Configuration registers.
   vrp_cfg_type cfg_ff;

   // Divider chain links; index 0 is fed by the front pipeline.
   logic               ch_valid [0:NM];
   logic               ch_ready [0:NM];
   logic [DM-1:0]      ch_div   [0:NM];
   logic [DM-1:0]      ch_rem_x [0:NM];
   logic [DM-1:0]      ch_rem_y [0:NM];
   logic [NM-1:0]      ch_numq_x [0:NM];
   logic [NM-1:0]      ch_numq_y [0:NM];
   vrp_flags_type      ch_flags [0:NM];

   // Output register.
   logic               rsp_valid_ff;
   logic [CW-1:0]      rsp_screen_x_ff, rsp_screen_y_ff, rsp_screen_x_in, rsp_screen_y_in;
   logic               rsp_behind_ff;
   logic               out_ready;
   logic               front_ready;

   // Apply the sign to a quotient magnitude and saturate it.
   function automatic logic [CW-1:0] sat_coord(input logic [NM-1:0] mag, input logic neg);
      logic [CW-1:0] res;
      if (neg) begin
         res = (mag > MAG_MAX) ? COORD_MIN : -mag[CW-1:0];
      end else begin
         res = (mag > MAG_MAX) ? COORD_MAX : mag[CW-1:0];
      end
      return res;
   endfunction

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle     <= COS_RESET;
         cfg_ff.sin_angle     <= SIN_RESET;
         cfg_ff.offset_x      <= OFFSET_RESET;
         cfg_ff.offset_y      <= OFFSET_RESET;
         cfg_ff.offset_z      <= OFFSET_RESET;
         cfg_ff.screen_width  <= WIDTH_RESET;
         cfg_ff.screen_height <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_COS_ANGLE:     cfg_ff.cos_angle     <= csr_data;
            CSR_SIN_ANGLE:     cfg_ff.sin_angle     <= csr_data;
            CSR_OFFSET_X:      cfg_ff.offset_x      <= csr_data;
            CSR_OFFSET_Y:      cfg_ff.offset_y      <= csr_data;
            CSR_OFFSET_Z:      cfg_ff.offset_z      <= csr_data;
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_data[SCREEN_WIDTH-1:0];
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_data[SCREEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Rotation, translation and scaling.
   vrp_front #(
      .CW(CW), .FB(FRAC_BITS), .RW(RW), .DW(DW), .NM(NM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_ready    (front_ready),
      .in_x        (req_vertex_x),
      .in_y        (req_vertex_y),
      .in_z        (req_vertex_z),
      .out_valid   (ch_valid[0]),
      .out_ready   (ch_ready[0]),
      .out_divisor (ch_div[0]),
      .out_mag_x   (ch_numq_x[0]),
      .out_mag_y   (ch_numq_y[0]),
      .out_flags   (ch_flags[0])
   );

   assign req_stall   = !front_ready;
   assign ch_rem_x[0] = '0;
   assign ch_rem_y[0] = '0;

   // One divider cell per quotient bit, most significant first.
   for (genvar i = 0; i < NM; i++) begin : g_cell
      vrp_div_cell #(.DM(DM), .NM(NM)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (ch_valid[i]),
         .in_ready    (ch_ready[i]),
         .in_divisor  (ch_div[i]),
         .in_rem_x    (ch_rem_x[i]),
         .in_rem_y    (ch_rem_y[i]),
         .in_numq_x   (ch_numq_x[i]),
         .in_numq_y   (ch_numq_y[i]),
         .in_flags    (ch_flags[i]),
         .out_valid   (ch_valid[i+1]),
         .out_ready   (ch_ready[i+1]),
         .out_divisor (ch_div[i+1]),
         .out_rem_x   (ch_rem_x[i+1]),
         .out_rem_y   (ch_rem_y[i+1]),
         .out_numq_x  (ch_numq_x[i+1]),
         .out_numq_y  (ch_numq_y[i+1]),
         .out_flags   (ch_flags[i+1])
      );
   end

   // Final sign, saturation and the behind-viewer override.
   always_comb begin
      if (ch_flags[NM].behind) begin
         rsp_screen_x_in = '0;
         rsp_screen_y_in = '0;
      end else begin
         rsp_screen_x_in = sat_coord(ch_numq_x[NM], ch_flags[NM].neg_x);
         rsp_screen_y_in = sat_coord(ch_numq_y[NM], ch_flags[NM].neg_y);
      end
   end

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign ch_ready[NM] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= ch_valid[NM];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_screen_x_ff <= rsp_screen_x_in;
         rsp_screen_y_ff <= rsp_screen_y_in;
         rsp_behind_ff   <= ch_flags[NM].behind;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_screen_x      = rsp_screen_x_ff;
   assign rsp_screen_y      = rsp_screen_y_ff;
   assign rsp_behind_viewer = rsp_behind_ff;

`ifndef SYNTHESIS
   // A vertex behind the viewer always projects to the origin.
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_behind_viewer |-> (rsp_screen_x == '0) && (rsp_screen_y == '0))
      else $error("behind-viewer item with nonzero coordinates");

   // The input is held off only when the whole pipeline is full and the output waits.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the pipeline has room");

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> verif/vrp_checker.sv
// Checker that predicts and compares the screen points of the vertex rotate and project block.
`timescale 1ns / 1ps

module vrp_checker #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [COORD_WIDTH-1:0]                req_vertex_x,
   input  logic [COORD_WIDTH-1:0]                req_vertex_y,
   input  logic [COORD_WIDTH-1:0]                req_vertex_z,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [COORD_WIDTH-1:0]                rsp_screen_x,
   input  logic [COORD_WIDTH-1:0]                rsp_screen_y,
   input  logic                                  rsp_behind_viewer,
   input  logic                                  csr_write,
   input  logic [vrp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [vrp_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   output int                                    error_count,
   output int                                    pending_count
);
   import vrp_pkg::*;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] screen_x;
      logic [COORD_WIDTH-1:0] screen_y;
      logic                   behind_viewer;
   } screen_point_type;

   // Shadow copy of the configuration registers.
   vrp_cfg_type cfg_shadow;

   // Screen points still to come out of the pipeline, oldest first.
   screen_point_type expected_points [$];

   // Rotate about the vertical axis, translate and project one vertex.
   function automatic screen_point_type project_vertex(input logic [COORD_WIDTH-1:0] vx,
                                                       input logic [COORD_WIDTH-1:0] vy,
                                                       input logic [COORD_WIDTH-1:0] vz);
      screen_point_type pt;
      longint x, y, z, c, s, rx, ry, rz, depth, wd, ht, scale, qx, qy, sat_hi, sat_lo;
      x  = longint'($signed(vx));
      y  = longint'($signed(vy));
      z  = longint'($signed(vz));
      c  = longint'($signed(cfg_shadow.cos_angle));
      s  = longint'($signed(cfg_shadow.sin_angle));
      // The arithmetic shift of a signed value rounds toward minus infinity.
      rx = ((x * c + z * s) >>> ANGLE_FRAC) + longint'($signed(cfg_shadow.offset_x));
      ry = y + longint'($signed(cfg_shadow.offset_y));
      rz = ((z * c - x * s) >>> ANGLE_FRAC) + longint'($signed(cfg_shadow.offset_z));
      depth = (longint'(1) <<< FRAC_BITS) + rz;
      wd = longint'(cfg_shadow.screen_width);
      ht = longint'(cfg_shadow.screen_height);
      scale = ((wd < ht) ? wd : ht) / 2;
      sat_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      sat_lo = -sat_hi - 1;
      if (depth <= 0) begin
         pt.screen_x      = '0;
         pt.screen_y      = '0;
         pt.behind_viewer = 1'b1;
      end else begin
         // Integer division truncates toward zero, then the quotient saturates.
         qx = (rx * scale) / depth;
         qy = (ry * scale) / depth;
         qx = (qx > sat_hi) ? sat_hi : ((qx < sat_lo) ? sat_lo : qx);
         qy = (qy > sat_hi) ? sat_hi : ((qy < sat_lo) ? sat_lo : qy);
         pt.screen_x      = qx[COORD_WIDTH-1:0];
         pt.screen_y      = qy[COORD_WIDTH-1:0];
         pt.behind_viewer = 1'b0;
      end
      return pt;
   endfunction

   // Sample all three ports at the clock edge; values are those from before the edge.
   always @(posedge clock) begin : monitor
      screen_point_type want;
      int               misses;
      misses = 0;
      if (reset) begin
         expected_points.delete();
         cfg_shadow = '{cos_angle: COS_RESET, sin_angle: SIN_RESET,
                        offset_x: OFFSET_RESET, offset_y: OFFSET_RESET,
                        offset_z: OFFSET_RESET, screen_width: WIDTH_RESET,
                        screen_height: HEIGHT_RESET};
      end else begin
         // Compare a delivered item with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("unexpected screen point: screen_x %0d, screen_y %0d, behind_viewer %0b",
                      $signed(rsp_screen_x), $signed(rsp_screen_y), rsp_behind_viewer);
               misses++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_screen_x !== want.screen_x) begin
                  $error("screen_x mismatch: expected %0d, got %0d",
                         $signed(want.screen_x), $signed(rsp_screen_x));
                  misses++;
               end
               if (rsp_screen_y !== want.screen_y) begin
                  $error("screen_y mismatch: expected %0d, got %0d",
                         $signed(want.screen_y), $signed(rsp_screen_y));
                  misses++;
               end
               if (rsp_behind_viewer !== want.behind_viewer) begin
                  $error("behind_viewer mismatch: expected %0b, got %0b",
                         want.behind_viewer, rsp_behind_viewer);
                  misses++;
               end
            end
         end

         // Predict the screen point of an accepted vertex.
         if (req_valid && !req_stall)
            expected_points.push_back(project_vertex(req_vertex_x, req_vertex_y, req_vertex_z));

         // Track register writes; an index past the list is ignored.
         if (csr_write) begin
            case (csr_index)
               CSR_COS_ANGLE:     cfg_shadow.cos_angle     = csr_data;
               CSR_SIN_ANGLE:     cfg_shadow.sin_angle     = csr_data;
               CSR_OFFSET_X:      cfg_shadow.offset_x      = csr_data;
               CSR_OFFSET_Y:      cfg_shadow.offset_y      = csr_data;
               CSR_OFFSET_Z:      cfg_shadow.offset_z      = csr_data;
               CSR_SCREEN_WIDTH:  cfg_shadow.screen_width  = csr_data[SCREEN_WIDTH-1:0];
               CSR_SCREEN_HEIGHT: cfg_shadow.screen_height = csr_data[SCREEN_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      error_count   <= error_count + misses;
      pending_count <= expected_points.size();
   end

endmodule

>>> verif/testbench.sv
// Stimulus, receiver stalls, watchdog and verdict for the vertex rotate and project block.
`timescale 1ns / 1ps

module testbench;
   import vrp_pkg::*;

   localparam int COORD_WIDTH  = 16;
   localparam int FRAC_BITS    = 12;
   localparam int PIPE_LATENCY = 37;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_PHASES    = 6;
   localparam int ITEMS_PER_PHASE  = 250;

   // Index past the register list; writes to it must leave the block unchanged.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [COORD_WIDTH-1:0]      req_vertex_x;
   logic [COORD_WIDTH-1:0]      req_vertex_y;
   logic [COORD_WIDTH-1:0]      req_vertex_z;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [COORD_WIDTH-1:0]      rsp_screen_x;
   logic [COORD_WIDTH-1:0]      rsp_screen_y;
   logic                        rsp_behind_viewer;
   logic                        csr_write;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_data;

   int             check_errors;
   int             check_pending;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   int             stall_left  = 0;
   stall_mode_type stall_mode  = STALL_NONE;

   vertex_rotate_project #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_vertex_x      (req_vertex_x),
      .req_vertex_y      (req_vertex_y),
      .req_vertex_z      (req_vertex_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_screen_x      (rsp_screen_x),
      .rsp_screen_y      (rsp_screen_y),
      .rsp_behind_viewer (rsp_behind_viewer),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   vrp_checker #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_vertex_x      (req_vertex_x),
      .req_vertex_y      (req_vertex_y),
      .req_vertex_z      (req_vertex_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_screen_x      (rsp_screen_x),
      .rsp_screen_y      (rsp_screen_y),
      .rsp_behind_viewer (rsp_behind_viewer),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_count       (check_errors),
      .pending_count     (check_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver stalls in stretches of varying density, including long solid runs.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(10, 200);
         rsp_stall  <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_left % 48) < 24);
         endcase
      end
   end

   // Count cycles in which no port moves anything.
   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // Offer one vertex and hold it until accepted; bursts are separated by random gaps.
   task automatic send_vertex(input logic [COORD_WIDTH-1:0] x,
                              input logic [COORD_WIDTH-1:0] y,
                              input logic [COORD_WIDTH-1:0] z);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 80);
      end
      req_valid    <= 1'b1;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_vertex_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // Stop sending and wait until every predicted item has come out.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (check_pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write all registers, then the unused index with random data.
   task automatic load_settings(input logic [15:0] cos_v, input logic [15:0] sin_v,
                                input logic [15:0] off_x, input logic [15:0] off_y,
                                input logic [15:0] off_z, input logic [15:0] wd,
                                input logic [15:0] ht);
      logic [CSR_DATA_WIDTH-1:0] vals [8];
      vals[CSR_COS_ANGLE]     = cos_v;
      vals[CSR_SIN_ANGLE]     = sin_v;
      vals[CSR_OFFSET_X]      = off_x;
      vals[CSR_OFFSET_Y]      = off_y;
      vals[CSR_OFFSET_Z]      = off_z;
      vals[CSR_SCREEN_WIDTH]  = wd;
      vals[CSR_SCREEN_HEIGHT] = ht;
      vals[CSR_UNUSED]        = 16'($urandom);
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(i);
         csr_data  <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] corner_value();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hC000;
         3:       return 16'h4000;
         default: return 16'h0000;
      endcase
   endfunction

   // Mostly legal frame sizes, with an occasional zero or an oversized write.
   function automatic logic [15:0] random_screen_dim();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'($urandom);
         default: return 16'($urandom_range(1, 4096));
      endcase
   endfunction

   initial begin
      logic [COORD_WIDTH-1:0] x, y, z;
      req_valid    = 1'b0;
      req_vertex_x = '0;
      req_vertex_y = '0;
      req_vertex_z = '0;
      csr_write    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      reset        = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset settings: field extremes, a zero and a negative divisor, and a divisor of one.
      send_vertex(16'h0000, 16'h0000, 16'h0000);
      send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vertex(16'h8000, 16'h8000, 16'h8000);
      send_vertex(16'h7FFF, 16'h8000, -16'sd4095);
      send_vertex(16'h8000, 16'h7FFF, -16'sd4095);
      send_vertex(16'd4096, 16'd4096, -16'sd4096);
      send_vertex(16'd4096, -16'sd4096, -16'sd4097);
      send_vertex(16'd100, -16'sd100, 16'h0000);
      send_vertex(16'hFFFF, 16'hFFFF, -16'sd4095);
      send_vertex(16'h5555, 16'hAAAA, 16'h0F0F);
      drain_pipeline();

      // Angles outside the unit range, extreme offsets and a zero frame width.
      load_settings(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'd4096);
      send_vertex(16'h0000, 16'h0000, 16'h0000);
      send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
      send_vertex(16'h8000, 16'h7FFF, 16'h8000);
      send_vertex(16'h1234, 16'hFEDC, 16'hF000);
      drain_pipeline();

      // Largest frame after masking, opposite offsets, negative cosine.
      load_settings(16'hC000, 16'h4000, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hF000);
      send_vertex(16'h0000, 16'h0000, 16'h0000);
      send_vertex(16'h7FFF, 16'h7FFF, 16'h8000);
      send_vertex(16'h8000, 16'h8000, 16'h7FFF);
      send_vertex(16'h0001, 16'hFFFF, 16'h4000);
      drain_pipeline();

      // Quarter turn with a square frame.
      load_settings(16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'd4096, 16'd4096);
      send_vertex(16'h7FFF, 16'h0000, 16'h0000);
      send_vertex(16'h8000, 16'h7FFF, 16'h0000);
      send_vertex(16'h1000, 16'h1000, 16'h1000);
      send_vertex(16'hF001, 16'h8000, 16'h7FFF);
      drain_pipeline();

      // Random phases, each under fresh settings.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 3)
            0: load_settings(16'($urandom_range(0, 32768) - 16384),
                             16'($urandom_range(0, 32768) - 16384),
                             16'($urandom_range(0, 8191) - 4096),
                             16'($urandom_range(0, 8191) - 4096),
                             16'($urandom_range(0, 8191) - 4096),
                             random_screen_dim(), random_screen_dim());
            1: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), random_screen_dim(), random_screen_dim());
            default: load_settings(corner_value(), corner_value(), corner_value(),
                                   corner_value(), corner_value(),
                                   random_screen_dim(), random_screen_dim());
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            case ($urandom_range(0, 2))
               0: begin
                  x = 16'($urandom);
                  y = 16'($urandom);
                  z = 16'($urandom);
               end
               1: begin
                  // Points in front of the viewer, where most projections land.
                  x = 16'($urandom_range(0, 16383) - 8192);
                  y = 16'($urandom_range(0, 16383) - 8192);
                  z = 16'($urandom_range(0, 10239) - 2048);
               end
               default: begin
                  // Depths near the viewer plane, where the divisor is tiny or crosses zero.
                  x = 16'($urandom);
                  y = 16'($urandom);
                  z = 16'($urandom_range(0, 400) - 4200);
               end
            endcase
            send_vertex(x, y, z);
            // Halfway through, hold off until the pipeline is empty.
            if (i == ITEMS_PER_PHASE / 2)
               drain_pipeline();
         end
         drain_pipeline();
      end

      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (check_errors == 0 && check_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
